// ----- sv/wpm_pkg.sv -----
// wpm_pkg: shared types and constants for the wildcard pattern matcher.
// Item structs, command codes, wildcard bytes and the cell control group.
// No dependencies.
package wpm_pkg;

   localparam int unsigned PATTERN_MAX_DEF = 32;
   localparam int unsigned LEN_W           = 6;

   localparam logic [1:0] CMD_PATTERN = 2'd0;
   localparam logic [1:0] CMD_TEXT    = 2'd1;
   localparam logic [1:0] CMD_END     = 2'd2;

   localparam logic [7:0] STAR_BYTE = 8'h2A;
   localparam logic [7:0] ANY_BYTE  = 8'h3F;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic             matched;
      logic             pattern_overflow;
      logic [LEN_W-1:0] pattern_len;
   } rsp_type;

   typedef struct packed {
      logic clear;   // new pattern: drop start bits
      logic reload;  // live bit takes the start bit
      logic step;    // live bit takes the text update
   } cell_ctl_type;

endpackage

// ----- sv/wildcard_pattern_matcher.sv -----
// wildcard_pattern_matcher: streamed wildcard ('*', '?') match against a loaded pattern.
// Row of wpm_cell instances, one per pattern position, and a wpm_out_buf result stage.
// Depends on wpm_pkg, wpm_cell, wpm_out_buf.
//
//   channel  | direction | ports                       | item
//   req      | in        | req_valid req_stall req_data | cmd + pattern/text byte
//   rsp      | out       | rsp_valid rsp_stall rsp_data | matched, overflow, length
//
// One item per cycle while req_stall is low: each text byte updates the whole row
// together, and the '*' cells ripple through the cell chain like a carry.
// An end item's result is registered in the result stage, in its skid entry while the output is stalled.
// Reset clears the pattern; no clearing pass.
// req_stall is high only while the skid entry of the result stage is occupied.
module wildcard_pattern_matcher #(
   parameter int unsigned PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wpm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wpm_pkg::rsp_type rsp_data
);
   import wpm_pkg::*;

   localparam int unsigned CW = $clog2(PATTERN_MAX + 1);

   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [CW-1:0]      count_base;
   logic               open_ff;
   logic               open_in;
   logic               ovf_ff;
   logic               ovf_in;
   logic               live0_ff;
   logic               live0_in;
   logic               accept;
   logic               is_pat;
   logic               new_pat;
   logic               is_text;
   logic               is_end;
   logic               full;
   logic               buf_full;
   cell_ctl_type       ctl;
   rsp_type            rsp_new;
   logic [PATTERN_MAX:0] live_row;
   logic [PATTERN_MAX:0] start_row;
   logic [PATTERN_MAX:0] nxt_row;

   always_comb begin
      accept     = req_valid && !req_stall;
      is_pat     = accept && (req_data.cmd == CMD_PATTERN);
      is_text    = accept && (req_data.cmd == CMD_TEXT);
      is_end     = accept && (req_data.cmd == CMD_END);
      new_pat    = is_pat && !open_ff;
      count_base = new_pat ? '0 : count_ff;
      full       = (count_base == CW'(PATTERN_MAX));

      ctl.clear  = new_pat;
      ctl.reload = is_pat || is_end;
      ctl.step   = is_text;

      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (is_pat) begin
         count_in = full ? count_base : count_base + 1'b1;
         ovf_in   = (new_pat ? 1'b0 : ovf_ff) | full;
      end

      open_in = open_ff;
      if (is_pat) begin
         open_in = 1'b1;
      end else if (is_text || is_end) begin
         open_in = 1'b0;
      end

      live0_in = live0_ff;
      if (ctl.reload) begin
         live0_in = 1'b1;
      end else if (ctl.step) begin
         live0_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         open_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
         live0_ff <= 1'b1;
      end else begin
         count_ff <= count_in;
         open_ff  <= open_in;
         ovf_ff   <= ovf_in;
         live0_ff <= live0_in;
      end
   end

   assign live_row[0]  = live0_ff;
   assign start_row[0] = 1'b1;
   assign nxt_row[0]   = 1'b0;

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      wpm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .wr_en      (is_pat && !full && (count_base == CW'(j))),
         .active     (count_ff > CW'(j)),
         .pat_ch     (req_data.ch),
         .text_ch    (req_data.ch),
         .diag_in    (live_row[j]),
         .chain_in   (nxt_row[j]),
         .start_prev (start_row[j]),
         .live_out   (live_row[j+1]),
         .nxt_out    (nxt_row[j+1]),
         .start_out  (start_row[j+1])
      );
   end

   always_comb begin
      rsp_new.matched          = live_row[count_ff];
      rsp_new.pattern_overflow = ovf_ff;
      rsp_new.pattern_len      = LEN_W'(count_ff);
   end

   wpm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (is_end),
      .in_data   (rsp_new),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   assign req_stall = buf_full;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(PATTERN_MAX))
      else $error("pattern count beyond capacity");

   a_overflow_means_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == CW'(PATTERN_MAX)))
      else $error("overflow flagged with room left");

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      is_end |=> rsp_valid)
      else $error("end item produced no result");

   a_reload_row: assert property (@(posedge clock) disable iff (reset)
      (is_pat || is_end) |=> (live_row == start_row))
      else $error("live row not restored from start row");

endmodule

// ----- sv/wpm_cell.sv -----
// wpm_cell: one pattern position of the matcher row.
// Holds the pattern byte, its start-row bit and its live-row bit.
// Depends on wpm_pkg.
module wpm_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  wpm_pkg::cell_ctl_type ctl,
   input  logic                 wr_en,
   input  logic                 active,
   input  logic [7:0]           pat_ch,
   input  logic [7:0]           text_ch,
   input  logic                 diag_in,
   input  logic                 chain_in,
   input  logic                 start_prev,
   output logic                 live_out,
   output logic                 nxt_out,
   output logic                 start_out
);
   import wpm_pkg::*;

   logic [7:0] pat_ff;
   logic       start_ff;
   logic       start_in;
   logic       live_ff;
   logic       live_in;
   logic       hit;

   always_comb begin
      hit = (text_ch == pat_ff) || (pat_ff == ANY_BYTE);
      if (!active) begin
         nxt_out = 1'b0;
      end else if (hit) begin
         nxt_out = diag_in;
      end else if (pat_ff == STAR_BYTE) begin
         nxt_out = chain_in | live_ff;
      end else begin
         nxt_out = 1'b0;
      end
   end

   always_comb begin
      if (wr_en) begin
         start_in = (pat_ch == STAR_BYTE) ? start_prev : 1'b0;
      end else if (ctl.clear) begin
         start_in = 1'b0;
      end else begin
         start_in = start_ff;
      end
      if (ctl.reload) begin
         live_in = start_in;
      end else if (ctl.step) begin
         live_in = nxt_out;
      end else begin
         live_in = live_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
         live_ff  <= 1'b0;
      end else begin
         start_ff <= start_in;
         live_ff  <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_ff <= pat_ch;
      end
   end

   assign live_out  = live_ff;
   assign start_out = start_ff;

endmodule

// ----- sv/wpm_out_buf.sv -----
// wpm_out_buf: result register plus one skid entry.
// Stall toward the input side is registered (skid occupied).
// Depends on wpm_pkg.
module wpm_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  wpm_pkg::rsp_type in_data,
   output logic             full,
   output logic             out_valid,
   output wpm_pkg::rsp_type out_data,
   input  logic             out_stall
);
   import wpm_pkg::*;

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;
   logic    out_free;

   always_comb begin
      out_free      = !out_valid_ff || !out_stall;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while result register empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> !skid_valid_ff)
      else $error("result pushed into a full buffer");

   a_skid_drains_first: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !out_stall) |=> (out_data_ff == $past(skid_data_ff)))
      else $error("skid entry overtaken");

endmodule

// ----- tb/sv/tb_wildcard_pattern_matcher.sv -----
// tb_wildcard_pattern_matcher: self-checking testbench for wildcard_pattern_matcher.
// Directed table, an overflow run, then random patterns and texts, scored against a row-based predictor.
// Depends on wpm_pkg and wildcard_pattern_matcher.
`timescale 1ns / 1ps

module tb_wildcard_pattern_matcher;
   import wpm_pkg::*;

   localparam int unsigned PMAX      = PATTERN_MAX_DEF;
   localparam logic [1:0]  CMD_BAD   = 2'd3;
   localparam int          QUIET_MAX = 1000;
   localparam int          N_ITEMS   = 1230;
   localparam int          N_ROWS    = 23;

   typedef struct packed {
      req_type it;
      bit      fixed;
      rsp_type want;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // typed expectation travels beside the item
   bit      row_fixed = 1'b0;
   rsp_type row_rsp = '0;

   int      errors = 0;
   int      sent_items = 0;
   int      idle_pct = 0;
   int      stall_left = 0;
   int      quiet_cycles = 0;

   // predictor state
   logic [7:0]    pat_mem [PMAX];
   int unsigned   pat_cnt = 0;
   logic [PMAX:0] start_bits = 1;
   logic [PMAX:0] live_bits = 1;
   bit            pat_open = 1'b0;
   bit            ovf_seen = 1'b0;
   rsp_type       verdict_q [$];

   // pattern as last loaded, for building matching texts
   logic [7:0]    pat_q [$];

   row_type dir_rows [N_ROWS] = '{
      '{'{CMD_END,     8'h00},     1'b1, '{1'b1, 1'b0, 6'd0}},
      '{'{CMD_TEXT,    8'h00},     1'b0, '0},
      '{'{CMD_END,     8'hFF},     1'b1, '{1'b0, 1'b0, 6'd0}},
      '{'{CMD_PATTERN, STAR_BYTE}, 1'b0, '0},
      '{'{CMD_END,     8'h00},     1'b1, '{1'b1, 1'b0, 6'd1}},
      '{'{CMD_TEXT,    8'hFF},     1'b0, '0},
      '{'{CMD_TEXT,    STAR_BYTE}, 1'b0, '0},
      '{'{CMD_END,     8'h00},     1'b0, '0},
      '{'{CMD_PATTERN, 8'h00},     1'b0, '0},
      '{'{CMD_PATTERN, ANY_BYTE},  1'b0, '0},
      '{'{CMD_BAD,     8'hFF},     1'b0, '0},
      '{'{CMD_PATTERN, STAR_BYTE}, 1'b0, '0},
      '{'{CMD_PATTERN, 8'hFF},     1'b0, '0},
      '{'{CMD_TEXT,    8'h00},     1'b0, '0},
      '{'{CMD_TEXT,    8'h41},     1'b0, '0},
      '{'{CMD_TEXT,    8'h42},     1'b0, '0},
      '{'{CMD_TEXT,    8'hFF},     1'b0, '0},
      '{'{CMD_END,     8'h00},     1'b0, '0},
      '{'{CMD_TEXT,    8'h00},     1'b0, '0},
      '{'{CMD_TEXT,    8'hFF},     1'b0, '0},
      '{'{CMD_END,     8'h00},     1'b0, '0},
      '{'{CMD_PATTERN, ANY_BYTE},  1'b0, '0},
      '{'{CMD_END,     8'h00},     1'b1, '{1'b0, 1'b0, 6'd1}}
   };

   wildcard_pattern_matcher #(
      .PATTERN_MAX(PMAX)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #10 clock = ~clock;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic advance_matcher(input req_type it, input bit fixed, input rsp_type fr);
      logic [PMAX:0] nxt;
      rsp_type       r;
      case (it.cmd)
         CMD_PATTERN: begin
            if (!pat_open) begin
               pat_cnt    = 0;
               ovf_seen   = 1'b0;
               start_bits = 1;
               pat_open   = 1'b1;
            end
            if (pat_cnt < PMAX) begin
               pat_mem[pat_cnt] = it.ch;
               start_bits[pat_cnt + 1] = (it.ch == STAR_BYTE) ? start_bits[pat_cnt] : 1'b0;
               pat_cnt++;
            end else begin
               ovf_seen = 1'b1;
            end
            live_bits = start_bits;
         end
         CMD_TEXT: begin
            pat_open = 1'b0;
            nxt = '0;
            for (int j = 0; j < pat_cnt; j++) begin
               if (it.ch == pat_mem[j] || pat_mem[j] == ANY_BYTE)
                  nxt[j + 1] = live_bits[j];
               else if (pat_mem[j] == STAR_BYTE)
                  nxt[j + 1] = nxt[j] | live_bits[j + 1];
               else
                  nxt[j + 1] = 1'b0;
            end
            live_bits = nxt;
         end
         CMD_END: begin
            pat_open = 1'b0;
            r.matched          = live_bits[pat_cnt];
            r.pattern_overflow = ovf_seen;
            r.pattern_len      = LEN_W'(pat_cnt);
            if (fixed) r = fr;
            verdict_q = {verdict_q, r};
            live_bits = start_bits;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type e;
      bit      moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            advance_matcher(req_data, row_fixed, row_rsp);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (verdict_q.size() == 0) begin
               report("unexpected result", rsp_data, 0);
            end else begin
               e = verdict_q.pop_front();
               if (rsp_data.matched !== e.matched)
                  report("matched", rsp_data.matched, e.matched);
               if (rsp_data.pattern_overflow !== e.pattern_overflow)
                  report("pattern_overflow", rsp_data.pattern_overflow, e.pattern_overflow);
               if (rsp_data.pattern_len !== e.pattern_len)
                  report("pattern_len", rsp_data.pattern_len, e.pattern_len);
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_MAX) begin
            $display("timeout: no item moved for %0d cycles", QUIET_MAX);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         rsp_stall = 1'b0;
         if (!reset && idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            stall_left = $urandom_range(1, 10);
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send(input req_type it, input bit fixed = 1'b0, input rsp_type fr = '0);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = it;
      row_fixed = fixed;
      row_rsp   = fr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (it.cmd != CMD_BAD) sent_items++;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (verdict_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'h61;
         3, 4:    return 8'h62;
         5, 6:    return STAR_BYTE;
         7:       return ANY_BYTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_text(input logic [7:0] b);
      if ($urandom_range(0, 39) == 0) begin
         // broken sequence: a pattern byte lands mid-text; it starts a new pattern unless one is still open
         send('{CMD_PATTERN, b});
         pat_q = '{b};
      end else begin
         send('{CMD_TEXT, b});
      end
      if ($urandom_range(0, 29) == 0) send('{CMD_BAD, 8'($urandom)});
   endtask

   task automatic random_sequence();
      int         plen;
      int         sel;
      logic [7:0] b;
      idle_pct = (sent_items > N_ITEMS - 150) ? 0 : ($urandom_range(0, 3) == 0 ? 0 : 20);
      sel = $urandom_range(0, 19);
      plen = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(30, 36) : $urandom_range(1, 8);
      if (plen != 0) pat_q.delete();
      for (int k = 0; k < plen; k++) begin
         b = pick_byte();
         send('{CMD_PATTERN, b});
         if (pat_q.size() < PMAX) pat_q = {pat_q, b};
         if ($urandom_range(0, 29) == 0) send('{CMD_BAD, 8'($urandom)});
      end
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 2) != 0) begin
            foreach (pat_q[k]) begin
               if (pat_q[k] == STAR_BYTE)
                  repeat ($urandom_range(0, 3)) send_text(pick_byte());
               else if ($urandom_range(0, 15) == 0)
                  send_text(pick_byte());
               else
                  send_text(pat_q[k] == ANY_BYTE ? pick_byte() : pat_q[k]);
            end
         end else begin
            repeat ($urandom_range(0, 10)) send_text(pick_byte());
         end
         send('{CMD_END, 8'($urandom)});
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].want);

      // full pattern plus dropped bytes
      for (int k = 0; k < PMAX + 2; k++)
         send('{CMD_PATTERN, k == 0 ? 8'h00 : k == PMAX + 1 ? 8'hFF : pick_byte()});
      repeat (4) send('{CMD_TEXT, pick_byte()});
      send('{CMD_END, 8'h00});

      drain();

      idle_pct = 20;
      while (sent_items < N_ITEMS) random_sequence();

      drain();
      repeat (5) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/wpm_pkg.sv
sv/wpm_cell.sv
sv/wpm_out_buf.sv
sv/wildcard_pattern_matcher.sv
tb/sv/tb_wildcard_pattern_matcher.sv
